### src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### src/rstpc_pkg.sv
// Types and constants shared by the range scan to point cloud modules.
package rstpc_pkg;

	localparam int XW      = 51;	// CORDIC vector width, signed
	localparam int ZW      = 34;	// residual angle width, signed, 2^-32 turn units
	localparam int ANG_W   = 16;	// binary angle units
	localparam int RANGE_W = 24;
	localparam int COORD_W = 25;
	localparam int NUM_W   = 20;
	localparam int VPS_W   = 21;
	localparam int PAW     = 5;

	// Inverse CORDIC gain, Q30
	localparam logic signed [30:0] KINV = 31'sd652032874;

	localparam logic signed [ANG_W-1:0] QUARTER_BAU = 16'sd16384;
	localparam logic signed [ZW-1:0]    HALF_TURN   = 34'sd2147483648;

	localparam logic signed [ZW-1:0] ATAN_TURNS [24] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
		34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
		34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
		34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
		34'sd652,       34'sd326,       34'sd163,       34'sd81
	};

	// Register indexes on the APB port
	localparam logic [2:0] REG_AZ_START = 3'd0;
	localparam logic [2:0] REG_AZ_STEP  = 3'd1;
	localparam logic [2:0] REG_EL_START = 3'd2;
	localparam logic [2:0] REG_EL_STEP  = 3'd3;
	localparam logic [2:0] REG_RANGE_LO = 3'd4;
	localparam logic [2:0] REG_RANGE_HI = 3'd5;
	localparam logic [2:0] REG_COLUMNS  = 3'd6;
	localparam logic [2:0] REG_ROWS     = 3'd7;

	// Sideband that travels with each transaction through the pipeline
	typedef struct packed {
		logic                    vld;
		logic                    good;
		logic                    last;
		logic [NUM_W-1:0]        number;
		logic [ANG_W-1:0]        az;
		logic [ANG_W-1:0]        el;
		logic signed [XW-1:0]    zkeep;
	} side_t;

endpackage

### src/rstpc_cell.sv
// One CORDIC rotation-mode iteration, registered.
module rstpc_cell import rstpc_pkg::*; #(
	parameter int STAGE = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic signed [XW-1:0] x_in,
	input  logic signed [XW-1:0] y_in,
	input  logic signed [ZW-1:0] z_in,
	input  side_t                side_in,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output logic signed [ZW-1:0] z_out,
	output side_t                side_out
);

	logic signed [XW-1:0] dx, dy, x_n, y_n;
	logic signed [ZW-1:0] z_n;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	side_t                side_s1;

	always_comb begin
		dx = y_in >>> STAGE;
		dy = x_in >>> STAGE;
		if (!z_in[ZW-1]) begin
			x_n = x_in - dx;
			y_n = y_in + dy;
			z_n = z_in - ATAN_TURNS[STAGE];
		end else begin
			x_n = x_in + dx;
			y_n = y_in - dy;
			z_n = z_in + ATAN_TURNS[STAGE];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x_n;
			y_s1 <= y_n;
			z_s1 <= z_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1 <= side_in;
		end
	end

	assign x_out    = x_s1;
	assign y_out    = y_s1;
	assign z_out    = z_s1;
	assign side_out = side_s1;

endmodule

### src/rstpc_kinv.sv
// Scale by the inverse CORDIC gain with floor, two partial products over two stages.
module rstpc_kinv import rstpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic signed [XW-1:0] v_in,
	input  side_t                side_in,
	output logic signed [XW-1:0] v_out,
	output side_t                side_out
);

	localparam int LOW_W = 25;
	localparam int PW    = XW - LOW_W + 31;
	localparam int SW    = PW + LOW_W;

	logic signed [XW-LOW_W-1:0] hi;
	logic signed [LOW_W:0]      lo;
	logic signed [PW-1:0]       phi_s1, plo_s1;
	logic signed [SW-1:0]       sum;
	logic signed [XW-1:0]       v_s2;
	side_t                      side_s1, side_s2;

	assign hi = v_in[XW-1:LOW_W];
	assign lo = $signed({1'b0, v_in[LOW_W-1:0]});

	always_ff @(posedge clk) begin
		if (adv) begin
			phi_s1 <= PW'(hi * KINV);
			plo_s1 <= PW'(lo * KINV);
		end
	end

	// floor(v * KINV / 2^30)
	assign sum = (SW'(phi_s1) <<< LOW_W) + SW'(plo_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s2 <= sum[30+XW-1:30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
			side_s2 <= '0;
		end else if (adv) begin
			side_s1 <= side_in;
			side_s2 <= side_s1;
		end
	end

	assign v_out    = v_s2;
	assign side_out = side_s2;

endmodule

### src/rstpc_rotator.sv
// Quadrant fold followed by a chain of CORDIC cells.
module rstpc_rotator import rstpc_pkg::*; #(
	parameter int STAGES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic signed [XW-1:0] mag,
	input  logic [ANG_W-1:0]     angle,
	input  side_t                side_in,
	output logic signed [XW-1:0] x_out,
	output logic signed [XW-1:0] y_out,
	output side_t                side_out
);

	logic signed [XW-1:0] x0;
	logic signed [ZW-1:0] z0, zw;
	logic signed [XW-1:0] x_s1;
	logic signed [ZW-1:0] z_s1;
	side_t                side_s1;

	logic signed [XW-1:0] xc [STAGES+1];
	logic signed [XW-1:0] yc [STAGES+1];
	logic signed [ZW-1:0] zc [STAGES+1];
	side_t                sc [STAGES+1];

	// Fold angles beyond a quarter turn: negate the vector, shift the angle half a turn toward zero
	always_comb begin
		zw = {{(ZW-ANG_W-16){angle[ANG_W-1]}}, angle, 16'b0};
		x0 = mag;
		z0 = zw;
		if ($signed(angle) > QUARTER_BAU) begin
			x0 = -mag;
			z0 = zw - HALF_TURN;
		end else if ($signed(angle) < -QUARTER_BAU) begin
			x0 = -mag;
			z0 = zw + HALF_TURN;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= x0;
			z_s1 <= z0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else if (adv) begin
			side_s1 <= side_in;
		end
	end

	assign xc[0] = x_s1;
	assign yc[0] = '0;
	assign zc[0] = z_s1;
	assign sc[0] = side_s1;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		rstpc_cell #(
			.STAGE(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.x_in    (xc[i]),
			.y_in    (yc[i]),
			.z_in    (zc[i]),
			.side_in (sc[i]),
			.x_out   (xc[i+1]),
			.y_out   (yc[i+1]),
			.z_out   (zc[i+1]),
			.side_out(sc[i+1])
		);
	end

	assign x_out    = xc[STAGES];
	assign y_out    = yc[STAGES];
	assign side_out = sc[STAGES];

endmodule

### src/range_scan_to_point_cloud.sv
// Throughput: one sample per cycle; every CORDIC iteration is its own cell in a chain,
// and the whole chain advances together whenever the output register is free or taken.
// Gain scaling takes two stages each time (two partial products, then sum and shift).
// Reset clears the pipeline valid bits, the column, row and point counters,
// and puts the configuration registers at their defaults; no clearing pass.
module range_scan_to_point_cloud import rstpc_pkg::*; #(
	parameter int MAX_COLUMNS   = 4096,
	parameter int MAX_ROWS      = 256,
	parameter int CORDIC_STAGES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// APB configuration
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PAW-1:0]            paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	// samples
	input  logic                      sample_valid,
	output logic                      sample_stall,
	input  logic [RANGE_W-1:0]        range_sample,
	input  logic                      sample_finite,
	// points
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic signed [COORD_W-1:0] x_pos,
	output logic signed [COORD_W-1:0] y_pos,
	output logic signed [COORD_W-1:0] z_pos,
	output logic                      point_valid,
	output logic                      scan_end,
	output logic [NUM_W-1:0]          point_number
);

	localparam int NSTAGE = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;
	localparam int CIW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CCW    = ($clog2(MAX_COLUMNS + 1) > 13) ? $clog2(MAX_COLUMNS + 1) : 13;
	localparam int RCW    = ($clog2(MAX_ROWS + 1) > 9) ? $clog2(MAX_ROWS + 1) : 9;
	localparam logic signed [XW:0] RND_HALF  = (XW+1)'(32768);
	localparam logic signed [XW:0] LIMIT_POS = (XW+1)'(16777215);
	localparam logic signed [XW:0] LIMIT_NEG = -(XW+1)'(16777215);

	// configuration registers
	logic [ANG_W-1:0]   az_start_q, az_step_q, el_start_q, el_step_q;
	logic [RANGE_W-1:0] range_lo_q, range_hi_q;
	logic [12:0]        columns_q;
	logic [8:0]         rows_q;

	// scan state
	logic [CIW-1:0]     col_q;
	logic [RIW-1:0]     row_q;
	logic [VPS_W-1:0]   vps_q;

	logic               adv, accept, cfg_wr;
	logic [CCW-1:0]     cols_eff;
	logic [RCW-1:0]     rows_eff;
	logic               last_col, last_row, good;
	side_t              side_front, side_k1, side_r1, side_k2in, side_k2, side_r2;
	logic signed [XW-1:0] v_front, mag1, ce, se, mag2, ca, sa;

	logic                      result_valid_q, point_valid_q, scan_end_q;
	logic signed [COORD_W-1:0] x_pos_q, y_pos_q, z_pos_q;
	logic [NUM_W-1:0]          point_number_q;

	function automatic logic signed [COORD_W-1:0] finish_coord(
		input logic signed [XW-1:0] v
	);
		logic signed [XW:0] t;
		t = ((XW+1)'(v) + RND_HALF) >>> 16;
		if (t > LIMIT_POS) begin
			t = LIMIT_POS;
		end else if (t < LIMIT_NEG) begin
			t = LIMIT_NEG;
		end
		return t[COORD_W-1:0];
	endfunction

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			az_start_q <= '0;
			az_step_q  <= '0;
			el_start_q <= '0;
			el_step_q  <= '0;
			range_lo_q <= '0;
			range_hi_q <= '1;
			columns_q  <= 13'd1;
			rows_q     <= 9'd1;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_AZ_START: az_start_q <= pwdata[ANG_W-1:0];
				REG_AZ_STEP:  az_step_q  <= pwdata[ANG_W-1:0];
				REG_EL_START: el_start_q <= pwdata[ANG_W-1:0];
				REG_EL_STEP:  el_step_q  <= pwdata[ANG_W-1:0];
				REG_RANGE_LO: range_lo_q <= pwdata[RANGE_W-1:0];
				REG_RANGE_HI: range_hi_q <= pwdata[RANGE_W-1:0];
				REG_COLUMNS:  columns_q  <= pwdata[12:0];
				REG_ROWS:     rows_q     <= pwdata[8:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_AZ_START: prdata = 32'(az_start_q);
			REG_AZ_STEP:  prdata = 32'(az_step_q);
			REG_EL_START: prdata = 32'(el_start_q);
			REG_EL_STEP:  prdata = 32'(el_step_q);
			REG_RANGE_LO: prdata = 32'(range_lo_q);
			REG_RANGE_HI: prdata = 32'(range_hi_q);
			REG_COLUMNS:  prdata = 32'(columns_q);
			REG_ROWS:     prdata = 32'(rows_q);
		endcase
	end

	// ---------------- front: counters, gating, angles ----------------
	assign adv          = !result_valid_q || !result_stall;
	assign sample_stall = !adv;
	assign accept       = sample_valid && adv;

	always_comb begin
		if (columns_q == '0) begin
			cols_eff = CCW'(1);
		end else if (CCW'(columns_q) > CCW'(MAX_COLUMNS)) begin
			cols_eff = CCW'(MAX_COLUMNS);
		end else begin
			cols_eff = CCW'(columns_q);
		end
		if (rows_q == '0) begin
			rows_eff = RCW'(1);
		end else if (RCW'(rows_q) > RCW'(MAX_ROWS)) begin
			rows_eff = RCW'(MAX_ROWS);
		end else begin
			rows_eff = RCW'(rows_q);
		end
	end

	// an index at or beyond the count wraps as the last one
	assign last_col = (CCW'(col_q) + CCW'(1)) >= cols_eff;
	assign last_row = (RCW'(row_q) + RCW'(1)) >= rows_eff;
	assign good     = sample_finite && (range_sample >= range_lo_q)
	                  && (range_sample <= range_hi_q);

	always_comb begin
		side_front.vld    = sample_valid;
		side_front.good   = good;
		side_front.last   = last_col && last_row;
		side_front.number = '0;
		if (good) begin
			side_front.number = vps_q[VPS_W-1] ? '1 : vps_q[NUM_W-1:0];
		end
		side_front.az     = az_start_q + ANG_W'(ANG_W'(col_q) * az_step_q);
		side_front.el     = el_start_q + ANG_W'(ANG_W'(row_q) * el_step_q);
		side_front.zkeep  = '0;
	end

	assign v_front = $signed({{(XW-RANGE_W-24){1'b0}}, range_sample, 24'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			vps_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				if (last_row) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RIW'(1);
				end
			end else begin
				col_q <= col_q + CIW'(1);
			end
			// scan end restarts the count even on a valid point
			if (last_col && last_row) begin
				vps_q <= '0;
			end else if (good && (vps_q != '1)) begin
				vps_q <= vps_q + VPS_W'(1);
			end
		end
	end

	// ---------------- elevation rotation ----------------
	rstpc_kinv u_kinv_range (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (v_front),
		.side_in (side_front),
		.v_out   (mag1),
		.side_out(side_k1)
	);

	rstpc_rotator #(
		.STAGES(NSTAGE)
	) u_rot_elev (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.mag     (mag1),
		.angle   (side_k1.el),
		.side_in (side_k1),
		.x_out   (ce),
		.y_out   (se),
		.side_out(side_r1)
	);

	// hold z alongside while the horizontal part is worked out
	always_comb begin
		side_k2in       = side_r1;
		side_k2in.zkeep = se;
	end

	// ---------------- azimuth rotation ----------------
	rstpc_kinv u_kinv_xy (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.v_in    (ce),
		.side_in (side_k2in),
		.v_out   (mag2),
		.side_out(side_k2)
	);

	rstpc_rotator #(
		.STAGES(NSTAGE)
	) u_rot_azim (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.mag     (mag2),
		.angle   (side_k2.az),
		.side_in (side_k2),
		.x_out   (ca),
		.y_out   (sa),
		.side_out(side_r2)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= side_r2.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_valid_q  <= side_r2.good;
			scan_end_q     <= side_r2.last;
			point_number_q <= side_r2.number;
			if (side_r2.good) begin
				x_pos_q <= finish_coord(ca);
				y_pos_q <= finish_coord(sa);
				z_pos_q <= finish_coord(side_r2.zkeep);
			end else begin
				x_pos_q <= '0;
				y_pos_q <= '0;
				z_pos_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign x_pos        = x_pos_q;
	assign y_pos        = y_pos_q;
	assign z_pos        = z_pos_q;
	assign point_valid  = point_valid_q;
	assign scan_end     = scan_end_q;
	assign point_number = point_number_q;

endmodule

### src/rstpc_checker.sv
// Port-level checker for the range scan to point cloud block, with its bind.
`include "assert_macros.svh"

module rstpc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               sample_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [24:0] x_pos,
	input logic signed [24:0] y_pos,
	input logic signed [24:0] z_pos,
	input logic               point_valid,
	input logic [19:0]        point_number
);

	// a dropped point carries no coordinates and no number
	`CHK_IMPLY(a_invalid_zero, clk, arst_n, result_valid && !point_valid, x_pos == 25'sd0 && y_pos == 25'sd0 && z_pos == 25'sd0 && point_number == 20'd0)

	// saturation is symmetric, the most negative code never shows
	`CHK_IMPLY(a_coord_sat, clk, arst_n, result_valid, x_pos != 25'h1000000 && y_pos != 25'h1000000 && z_pos != 25'h1000000)

	// with the output register empty the input side must not stall
	`CHK_IMPLY(a_free_when_empty, clk, arst_n, !result_valid, !sample_stall)

	// a stalled transaction holds
	`CHK_NEXT(a_hold_stalled, clk, arst_n, result_valid && result_stall, result_valid && $stable(x_pos) && $stable(point_number))

endmodule

bind range_scan_to_point_cloud rstpc_checker u_rstpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.sample_stall(sample_stall),
	.result_valid(result_valid),
	.result_stall(result_stall),
	.x_pos       (x_pos),
	.y_pos       (y_pos),
	.z_pos       (z_pos),
	.point_valid (point_valid),
	.point_number(point_number)
);
